@@ rtl/dq_pkg.sv @@
// Package with the shared constants and types of the double-ended queue.
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int OCC_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_PEEK_BACK  = 3'd4,
    OP_PEEK_FRONT = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_COUNT      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_R,
    CELL_SHIFT_L,
    CELL_APPEND,
    CELL_DROP_LAST,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t              kind;
    logic [DATA_W-1:0]     value;
  } cell_cmd_t;

  typedef struct packed {
    op_t                   op;
    logic [VALUE_W-1:0]    value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]    data_out;
    status_t               status;
    logic [OCC_W-1:0]      occupancy;
  } out_item_t;

endpackage

@@ rtl/dq_cell.sv @@
// One storage cell of the queue chain, trading its element with its neighbors.
module dq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_pkg::cell_cmd_t          cmd,
  input  logic [dq_pkg::DATA_W-1:0]  left_data,
  input  logic                       left_valid,
  input  logic [dq_pkg::DATA_W-1:0]  right_data,
  input  logic                       right_valid,
  output logic [dq_pkg::DATA_W-1:0]  data,
  output logic                       valid,
  output logic                       last
);

  logic [dq_pkg::DATA_W-1:0] data_r;
  logic [dq_pkg::DATA_W-1:0] data_nxt;
  logic                      valid_r;
  logic                      valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (cmd.kind)
      dq_pkg::CELL_SHIFT_R: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      dq_pkg::CELL_SHIFT_L: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
      end
      dq_pkg::CELL_APPEND: begin
        if (!valid_r && left_valid) begin
          data_nxt  = cmd.value;
          valid_nxt = 1'b1;
        end
      end
      dq_pkg::CELL_DROP_LAST: begin
        if (valid_r && !right_valid) begin
          valid_nxt = 1'b0;
        end
      end
      dq_pkg::CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data  = data_r;
  assign valid = valid_r;
  assign last  = valid_r && !right_valid;

endmodule

@@ rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue built from a chain of cells.
// Each transaction is one operation: push or pop at either end, peek at either end,
// clear, or a count query, and each returns exactly one result with the removed or
// peeked element, a status and the occupancy after the operation. The elements sit in
// a row of DEPTH cells in order from front to back; a push at the front shifts the
// whole row one cell toward the back, and a pop from the front shifts it back. One
// operation is taken every cycle: the only limit is the single result register, which
// accepts a new transaction in the same cycle its result is taken. The registered
// result appears in the next cycle. A push to a full queue reports a full error and
// a pop or peek on an empty queue an empty error; neither changes the contents.
module double_ended_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dq_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dq_pkg::out_item_t out_data
);

  logic [dq_pkg::DATA_W-1:0] cell_data  [dq_pkg::DEPTH];
  logic                      cell_valid [dq_pkg::DEPTH];
  logic                      cell_last  [dq_pkg::DEPTH];

  dq_pkg::cell_cmd_t         cmd;
  logic [dq_pkg::DATA_W-1:0] push_value;
  logic [dq_pkg::DATA_W-1:0] back_data;
  logic [dq_pkg::DATA_W-1:0] rd_data;
  dq_pkg::status_t           status;
  dq_pkg::cell_op_t          kind;
  logic                      fire;
  logic                      empty;
  logic                      full;

  logic [dq_pkg::CNT_W-1:0]  count_r;
  logic [dq_pkg::CNT_W-1:0]  count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  dq_pkg::out_item_t         out_data_r;

  assign in_ready   = !out_valid_r || out_ready;
  assign fire       = in_valid && in_ready;
  assign empty      = (count_r == '0);
  assign full       = (count_r == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign push_value = dq_pkg::DATA_W'(in_data.value);

  always_comb begin
    back_data = '0;
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      back_data = back_data | (cell_data[i] & {dq_pkg::DATA_W{cell_last[i]}});
    end
  end

  always_comb begin
    kind      = dq_pkg::CELL_HOLD;
    status    = dq_pkg::ST_OK;
    rd_data   = '0;
    count_nxt = count_r;
    unique case (in_data.op)
      dq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          kind      = dq_pkg::CELL_APPEND;
          count_nxt = count_r + 1'b1;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          kind      = dq_pkg::CELL_DROP_LAST;
          rd_data   = back_data;
          count_nxt = count_r - 1'b1;
        end
      end
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          kind      = dq_pkg::CELL_SHIFT_R;
          count_nxt = count_r + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          kind      = dq_pkg::CELL_SHIFT_L;
          rd_data   = cell_data[0];
          count_nxt = count_r - 1'b1;
        end
      end
      dq_pkg::OP_PEEK_BACK: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          rd_data = back_data;
        end
      end
      dq_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          rd_data = cell_data[0];
        end
      end
      dq_pkg::OP_CLEAR: begin
        kind      = dq_pkg::CELL_CLEAR;
        count_nxt = '0;
      end
      dq_pkg::OP_COUNT: begin
      end
      default: begin
      end
    endcase
  end

  assign cmd = {(fire ? kind : dq_pkg::CELL_HOLD), push_value};

  genvar g;
  generate
    for (g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
      logic [dq_pkg::DATA_W-1:0] l_data;
      logic                      l_valid;
      logic [dq_pkg::DATA_W-1:0] r_data;
      logic                      r_valid;

      if (g == 0) begin : g_head
        assign l_data  = push_value;
        assign l_valid = 1'b1;
      end else begin : g_link_l
        assign l_data  = cell_data[g-1];
        assign l_valid = cell_valid[g-1];
      end

      if (g == dq_pkg::DEPTH - 1) begin : g_tail
        assign r_data  = '0;
        assign r_valid = 1'b0;
      end else begin : g_link_r
        assign r_data  = cell_data[g+1];
        assign r_valid = cell_valid[g+1];
      end

      dq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .left_data   (l_data),
        .left_valid  (l_valid),
        .right_data  (r_data),
        .right_valid (r_valid),
        .data        (cell_data[g]),
        .valid       (cell_valid[g]),
        .last        (cell_last[g])
      );
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.data_out  <= dq_pkg::VALUE_W'(rd_data);
      out_data_r.status    <= status;
      out_data_r.occupancy <= dq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
